// ===== rtl/gsfq_pkg.sv =====
// Package for the grouped slot free queue.
// Holds sizes, codes and the struct types shared by the controller, the
// datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package gsfq_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 256;
    localparam int MAX_GROUPS  = 4;
    localparam int PTR_W       = $clog2(TABLE_SLOTS);
    localparam int FILL_W      = PTR_W + 1;
    localparam int GRP_W       = $clog2(MAX_GROUPS);
    localparam int GCNT_W      = 3;
    localparam int STORE_DEPTH = MAX_GROUPS * TABLE_SLOTS;
    localparam int STORE_AW    = GRP_W + PTR_W;
    localparam int SLOT_W      = 8;
    localparam int SUM_W       = FILL_W + 2;

    // Configuration register file
    localparam int CFG_SIZE_REGS = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DESC_COUNT   = 3'd0,
        CFG_GROUP_COUNT  = 3'd1,
        CFG_GROUP_SIZE_0 = 3'd2,
        CFG_GROUP_SIZE_1 = 3'd3,
        CFG_GROUP_SIZE_2 = 3'd4,
        CFG_GROUP_SIZE_3 = 3'd5
    } t_cfg_idx;

    // Request operations
    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_GROUP  = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_FULL       = 3'd3,
        ST_BAD_CONFIG = 3'd4
    } t_status;

    // One request
    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        group;
        logic [SLOT_W-1:0] slot;
    } t_req;

    // One result
    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic [8:0]        free_left;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic fill;
        logic resp;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_init;
        logic cfg_ok;
        logic fill_last;
    } t_dp_status;

endpackage

// ===== rtl/gsfq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-group queue rings. No dependencies.
`timescale 1ns / 1ps

module gsfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gsfq_ctrl.sv =====
// Controller for the grouped slot free queue: sequences request capture,
// execution, the init fill sweep and the result cycle. Uses gsfq_pkg.
`timescale 1ns / 1ps

module gsfq_ctrl
    import gsfq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_sts,
    output t_ctrl_cmd  o_cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_FILL = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    // Take a new request while idle or while the previous result is shown
    assign busy   = (r_state != S_IDLE) && (r_state != S_RESP);
    assign accept = start && !busy;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = accept;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_init && i_sts.cfg_ok) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                o_cmd.resp = 1'b1;
                n_state    = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/gsfq_dp.sv =====
// Datapath for the grouped slot free queue: configuration registers,
// per-group head, tail and fill, the init sweep and the queue RAM.
// Uses gsfq_pkg and gsfq_ram.
`timescale 1ns / 1ps

module gsfq_dp
    import gsfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req                  i_req,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_sts,
    output t_result               o_result
);

    // Configuration
    logic [FILL_W-1:0]  r_desc;
    logic [GCNT_W-1:0]  r_gcount;
    logic [FILL_W-1:0]  r_gsize [CFG_SIZE_REGS];

    // Queue bookkeeping
    logic [PTR_W-1:0]   r_head [MAX_GROUPS], n_head [MAX_GROUPS];
    logic [PTR_W-1:0]   r_tail [MAX_GROUPS], n_tail [MAX_GROUPS];
    logic [FILL_W-1:0]  r_fill [MAX_GROUPS], n_fill [MAX_GROUPS];
    logic [GCNT_W-1:0]  r_in_use, n_in_use;

    // Request and result
    t_req               r_req;
    logic [2:0]         r_status, n_status;
    logic               r_popped, n_popped;

    // Init sweep
    logic [GRP_W-1:0]   r_fgrp, n_fgrp;
    logic [FILL_W-1:0]  r_fpos, n_fpos;
    logic [PTR_W-1:0]   r_foff, n_foff;

    logic [SUM_W-1:0]   size_sum;
    logic               cfg_ok;
    logic [GCNT_W-1:0]  num_groups;
    logic [FILL_W-1:0]  cur_size;
    logic               fill_last;
    logic               good;
    logic [GRP_W-1:0]   g;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [SLOT_W-1:0]   ram_wdata;
    logic [STORE_AW-1:0] ram_raddr;
    logic [SLOT_W-1:0]   ram_rdata;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc   <= FILL_W'(TABLE_SLOTS);
            r_gcount <= '0;
            for (int i = 0; i < CFG_SIZE_REGS; i++) begin
                r_gsize[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DESC_COUNT:   r_desc     <= i_cfg_data;
                CFG_GROUP_COUNT:  r_gcount   <= i_cfg_data[GCNT_W-1:0];
                CFG_GROUP_SIZE_0: r_gsize[0] <= i_cfg_data;
                CFG_GROUP_SIZE_1: r_gsize[1] <= i_cfg_data;
                CFG_GROUP_SIZE_2: r_gsize[2] <= i_cfg_data;
                CFG_GROUP_SIZE_3: r_gsize[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Check the configuration: sizes of used groups must fit the table
    always_comb begin
        size_sum = '0;
        for (int i = 0; i < CFG_SIZE_REGS; i++) begin
            if (GCNT_W'(i) < r_gcount) begin
                size_sum = size_sum + SUM_W'(r_gsize[i]);
            end
        end
    end

    assign cfg_ok = (r_desc != '0) && (r_desc <= FILL_W'(TABLE_SLOTS)) &&
                    (r_gcount <= GCNT_W'(MAX_GROUPS)) &&
                    (size_sum <= SUM_W'(r_desc));

    // Init sweep geometry
    assign num_groups = (r_gcount == '0) ? GCNT_W'(1) : r_gcount;
    assign cur_size   = (r_gcount == '0) ? r_desc : r_gsize[r_fgrp];
    assign fill_last  = (r_fpos == cur_size) &&
                        (GCNT_W'(r_fgrp) == num_groups - GCNT_W'(1));

    assign g    = r_req.group;
    assign good = GCNT_W'(g) < r_in_use;

    assign o_sts.is_init   = (r_req.op == OP_INIT);
    assign o_sts.cfg_ok    = cfg_ok;
    assign o_sts.fill_last = fill_last;

    // Next-state logic for queues, request execution and the sweep
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_in_use  = r_in_use;
        n_status  = r_status;
        n_popped  = r_popped;
        n_fgrp    = r_fgrp;
        n_fpos    = r_fpos;
        n_foff    = r_foff;
        ram_we    = 1'b0;
        ram_waddr = {g, r_tail[g]};
        ram_wdata = r_req.slot;

        if (i_cmd.exec) begin
            n_status = ST_OK;
            n_popped = 1'b0;
            case (r_req.op)
                OP_INIT: begin
                    // Drop every queue, then refill if the setup is sound
                    for (int i = 0; i < MAX_GROUPS; i++) begin
                        n_head[i] = '0;
                        n_tail[i] = '0;
                        n_fill[i] = '0;
                    end
                    n_in_use = '0;
                    n_fgrp   = '0;
                    n_fpos   = '0;
                    n_foff   = '0;
                    if (!cfg_ok) begin
                        n_status = ST_BAD_CONFIG;
                    end
                end
                OP_ALLOC: begin
                    if (!good) begin
                        n_status = ST_BAD_GROUP;
                    end else if (r_fill[g] == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped  = 1'b1;
                        n_head[g] = (r_head[g] == PTR_W'(TABLE_SLOTS - 1)) ?
                                    '0 : r_head[g] + PTR_W'(1);
                        n_fill[g] = r_fill[g] - FILL_W'(1);
                    end
                end
                OP_RELEASE: begin
                    if (!good) begin
                        n_status = ST_BAD_GROUP;
                    end else if (r_fill[g] == FILL_W'(TABLE_SLOTS)) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        n_tail[g] = (r_tail[g] == PTR_W'(TABLE_SLOTS - 1)) ?
                                    '0 : r_tail[g] + PTR_W'(1);
                        n_fill[g] = r_fill[g] + FILL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.fill) begin
            if (r_fpos != cur_size) begin
                // Write one consecutive index into the current group's ring
                ram_we    = 1'b1;
                ram_waddr = {r_fgrp, r_fpos[PTR_W-1:0]};
                ram_wdata = r_foff + r_fpos[PTR_W-1:0];
                n_fpos    = r_fpos + FILL_W'(1);
            end else begin
                // Close this group and move to the next
                n_head[r_fgrp] = '0;
                n_tail[r_fgrp] = (cur_size == FILL_W'(TABLE_SLOTS)) ?
                                 '0 : cur_size[PTR_W-1:0];
                n_fill[r_fgrp] = cur_size;
                n_fgrp         = r_fgrp + GRP_W'(1);
                n_fpos         = '0;
                n_foff         = r_foff + cur_size[PTR_W-1:0];
                if (fill_last) begin
                    n_in_use = num_groups;
                end
            end
        end
    end

    // Queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
            r_in_use <= '0;
            r_popped <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
            r_in_use <= n_in_use;
            r_popped <= n_popped;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        r_status <= n_status;
        r_fgrp   <= n_fgrp;
        r_fpos   <= n_fpos;
        r_foff   <= n_foff;
    end

    // Pop address is read in the execute cycle; data lands for the result
    assign ram_raddr = {g, r_head[g]};

    gsfq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result fields
    assign o_result.status     = r_status;
    assign o_result.slot_index = r_popped ? ram_rdata : '0;
    assign o_result.free_left  = good ? r_fill[g] : '0;

endmodule

// ===== rtl/grouped_slot_free_queue.sv =====
// Grouped slot free queue: per-group FIFO free lists of slot indices with an
// init sweep driven by the configuration registers. The receiver cannot stall:
// a result is on o_result for the single cycle that o_done is high. On allocate,
// release and any request that is refused, busy is high for the execute cycle,
// in which the queue RAM is read or written once, and the result follows in the
// next cycle, during which the next start is taken. An init with a sound
// configuration then runs the sweep over the slots handed out (at most 256):
// it writes one index per cycle through the single RAM write port and closes
// each group in a step of its own, and the result follows the last group.
// Uses gsfq_pkg, gsfq_ctrl and gsfq_dp.
`timescale 1ns / 1ps

module grouped_slot_free_queue
    import gsfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status sts;

    gsfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    gsfq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result)
    );

    assign o_done = cmd.resp;

    // An accepted request always occupies the execute cycle next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && cmd.exec))
        else $error("accepted request did not enter execute");

    // A result is shown for a single cycle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // A popped index is reported only on success
    a_slot_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |-> (o_result.slot_index == '0))
        else $error("slot index given with a failing status");

    // A refused group reports no free entries
    a_bad_group_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_BAD_GROUP)) |-> (o_result.free_left == '0))
        else $error("free count given for a bad group");

endmodule

// ===== verif/grouped_slot_free_queue_checker.sv =====
// Checker for the grouped slot free queue: watches the request, result and
// register write ports, predicts each result and compares it field by field.
// Depends on gsfq_pkg only.
`timescale 1ns / 1ps

module grouped_slot_free_queue_checker
    import gsfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_req                  i_req,
    input  logic                  i_done,
    input  t_result               i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int MAX_PRINTED = 40;

    // Shadow of the free queues
    logic [SLOT_W-1:0] slot_ring [MAX_GROUPS][TABLE_SLOTS];
    int ring_head [MAX_GROUPS];
    int ring_tail [MAX_GROUPS];
    int ring_fill [MAX_GROUPS];
    int groups_live;

    // Shadow of the register file
    int cfg_desc;
    int cfg_groups;
    int cfg_size [CFG_SIZE_REGS];

    t_result outcome_q [$];
    int      error_count = 0;

    assign o_errors = error_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic void empty_queues();
        for (int g = 0; g < MAX_GROUPS; g++) begin
            ring_head[g] = 0;
            ring_tail[g] = 0;
            ring_fill[g] = 0;
        end
        groups_live = 0;
    endfunction

    // Hand group g the n consecutive indices from first on
    function automatic void load_group(input int g, input int first, input int n);
        for (int j = 0; j < n; j++)
            slot_ring[g][j] = SLOT_W'(first + j);
        ring_head[g] = 0;
        ring_tail[g] = n % TABLE_SLOTS;
        ring_fill[g] = n;
    endfunction

    function automatic t_status rebuild_queues();
        int sum;
        int offset;
        sum    = 0;
        offset = 0;
        if (cfg_desc == 0 || cfg_desc > TABLE_SLOTS || cfg_groups > MAX_GROUPS) begin
            empty_queues();
            return ST_BAD_CONFIG;
        end
        for (int g = 0; g < cfg_groups; g++)
            sum += cfg_size[g];
        empty_queues();
        if (sum > cfg_desc)
            return ST_BAD_CONFIG;
        if (cfg_groups == 0) begin
            load_group(0, 0, cfg_desc);
            groups_live = 1;
        end else begin
            for (int g = 0; g < cfg_groups; g++) begin
                load_group(g, offset, cfg_size[g]);
                offset += cfg_size[g];
            end
            groups_live = cfg_groups;
        end
        return ST_OK;
    endfunction

    // Apply one request to the shadow queues and return the result it gives
    function automatic t_result compute_outcome(input t_req r);
        t_result res;
        t_status st;
        int      g;
        g  = r.group;
        st = ST_OK;
        res.slot_index = '0;
        case (r.op)
            OP_INIT: st = rebuild_queues();
            OP_ALLOC: begin
                if (g >= groups_live) begin
                    st = ST_BAD_GROUP;
                end else if (ring_fill[g] == 0) begin
                    st = ST_EMPTY;
                end else begin
                    res.slot_index = slot_ring[g][ring_head[g]];
                    ring_head[g]   = (ring_head[g] + 1) % TABLE_SLOTS;
                    ring_fill[g]--;
                end
            end
            OP_RELEASE: begin
                if (g >= groups_live) begin
                    st = ST_BAD_GROUP;
                end else if (ring_fill[g] >= TABLE_SLOTS) begin
                    st = ST_FULL;
                end else begin
                    slot_ring[g][ring_tail[g]] = r.slot;
                    ring_tail[g] = (ring_tail[g] + 1) % TABLE_SLOTS;
                    ring_fill[g]++;
                end
            end
            default: ;
        endcase
        res.status    = st;
        res.free_left = (g < groups_live) ? 9'(ring_fill[g]) : '0;
        return res;
    endfunction

    // Track register writes, check results, predict accepted requests
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_desc   = TABLE_SLOTS;
            cfg_groups = 0;
            for (int k = 0; k < CFG_SIZE_REGS; k++)
                cfg_size[k] = 0;
            empty_queues();
            outcome_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DESC_COUNT:   cfg_desc    = i_cfg_data;
                    CFG_GROUP_COUNT:  cfg_groups  = i_cfg_data[GCNT_W-1:0];
                    CFG_GROUP_SIZE_0: cfg_size[0] = i_cfg_data;
                    CFG_GROUP_SIZE_1: cfg_size[1] = i_cfg_data;
                    CFG_GROUP_SIZE_2: cfg_size[2] = i_cfg_data;
                    CFG_GROUP_SIZE_3: cfg_size[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result with no request pending", 1, 0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_result.status !== want.status)
                        report_mismatch("status", i_result.status, want.status);
                    if (i_result.slot_index !== want.slot_index)
                        report_mismatch("slot_index", i_result.slot_index, want.slot_index);
                    if (i_result.free_left !== want.free_left)
                        report_mismatch("free_left", i_result.free_left, want.free_left);
                end
            end
            if (i_start && !i_busy)
                outcome_q.push_back(compute_outcome(i_req));
            o_pending <= outcome_q.size();
        end
    end

endmodule

// ===== verif/grouped_slot_free_queue_tb.sv =====
// Testbench top for the grouped slot free queue: drives requests and register
// writes, runs a watchdog and gives the verdict.
// Depends on gsfq_pkg, grouped_slot_free_queue and grouped_slot_free_queue_checker.
`timescale 1ns / 1ps

module grouped_slot_free_queue_tb;
    import gsfq_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1700;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 20;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int errors;
    int pending;
    int idle_pct;
    int stall_cycles;
    int n_items;
    int n_inits;
    int n_settings;
    int cur_groups;

    grouped_slot_free_queue i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    grouped_slot_free_queue_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (i_req),
        .i_done     (o_done),
        .i_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort when neither a request nor a result moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one request, with a random gap first, and hold until taken
    task automatic send_req(input logic [1:0] op, input logic [1:0] grp,
                            input logic [SLOT_W-1:0] slot);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_req <= '{op: op, group: grp, slot: slot};
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_items++;
        if (op == OP_INIT)
            n_inits++;
    endtask

    // Drop start and hold until every result is back
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic load_config(input int desc, input int gcnt,
                               input int s0, input int s1, input int s2, input int s3);
        write_reg(CFG_DESC_COUNT, desc);
        write_reg(CFG_GROUP_COUNT, gcnt);
        write_reg(CFG_GROUP_SIZE_0, s0);
        write_reg(CFG_GROUP_SIZE_1, s1);
        write_reg(CFG_GROUP_SIZE_2, s2);
        write_reg(CFG_GROUP_SIZE_3, s3);
        i_cfg_we <= 1'b0;
        n_settings++;
        cur_groups = (gcnt == 0) ? 1 : ((gcnt > MAX_GROUPS) ? MAX_GROUPS : gcnt);
    endtask

    // Draw a setting: mostly legal, small groups, with extremes and bad ones mixed in
    task automatic pick_config();
        int kind;
        int desc;
        int gcnt;
        int left;
        int sz [4];
        kind = $urandom_range(99);
        for (int k = 0; k < 4; k++)
            sz[k] = $urandom_range(511);
        if (kind < 20) begin
            gcnt = 0;
            desc = ($urandom_range(2) == 0) ? TABLE_SLOTS : $urandom_range(1, TABLE_SLOTS);
        end else if (kind < 70) begin
            gcnt = $urandom_range(1, MAX_GROUPS);
            desc = ($urandom_range(9) == 0) ? TABLE_SLOTS : $urandom_range(1, 64);
            left = desc;
            for (int k = 0; k < gcnt; k++) begin
                if ($urandom_range(9) == 0)
                    sz[k] = left;
                else
                    sz[k] = $urandom_range(0, (left < 16) ? left : 16);
                left -= sz[k];
            end
        end else if (kind < 78) begin
            gcnt = $urandom_range(7);
            desc = ($urandom_range(1) == 0) ? 0 : $urandom_range(TABLE_SLOTS + 1, 511);
        end else if (kind < 86) begin
            gcnt = $urandom_range(MAX_GROUPS + 1, 7);
            desc = $urandom_range(1, TABLE_SLOTS);
        end else begin
            // sizes add up past the table
            gcnt  = $urandom_range(1, MAX_GROUPS);
            desc  = $urandom_range(1, 200);
            sz[0] = ($urandom_range(1) == 0) ? desc + 1 : $urandom_range(desc + 1, 511);
        end
        load_config(desc, gcnt, sz[0], sz[1], sz[2], sz[3]);
    endtask

    // One random request: mostly allocate and release on live groups
    task automatic random_req();
        int          pick;
        logic [1:0]  grp;
        grp  = 2'($urandom_range(cur_groups - 1));
        pick = $urandom_range(99);
        if (pick < 45)
            send_req(OP_ALLOC, grp, 8'($urandom_range(255)));
        else if (pick < 85)
            send_req(OP_RELEASE, grp, 8'($urandom_range(255)));
        else if (pick < 88)
            send_req(OP_INIT, 2'($urandom_range(3)), 8'($urandom_range(255)));
        else if (pick < 92)
            send_req(OP_UNUSED, 2'($urandom_range(3)), 8'($urandom_range(255)));
        else
            send_req(($urandom_range(1) == 0) ? OP_ALLOC : OP_RELEASE,
                     2'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    initial begin
        int phase_len;
        int random_sent;
        int idle_choice [4];
        int phase;

        idle_choice  = '{0, 53, 0, 18};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        stall_cycles = 0;
        idle_pct     = 0;
        n_items      = 0;
        n_inits      = 0;
        n_settings   = 0;
        cur_groups   = 1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before any init every group is refused; unused op is ignored
        send_req(OP_ALLOC, 2'd0, 8'h00);
        send_req(OP_RELEASE, 2'd3, 8'hFF);
        send_req(OP_UNUSED, 2'd0, 8'h00);
        // Reset setting: one group of the whole table, queue starts full
        send_req(OP_INIT, 2'd0, 8'h00);
        send_req(OP_RELEASE, 2'd0, 8'hFF);
        send_req(OP_ALLOC, 2'd0, 8'h00);
        send_req(OP_ALLOC, 2'd1, 8'h00);
        send_req(OP_RELEASE, 2'd0, 8'hAA);
        send_req(OP_ALLOC, 2'd0, 8'h55);

        // Four groups whose sizes use up exactly the table, one group empty
        wait_idle();
        load_config(10, 4, 3, 0, 5, 2);
        send_req(OP_INIT, 2'd3, 8'h00);
        send_req(OP_ALLOC, 2'd1, 8'h00);
        send_req(OP_RELEASE, 2'd1, 8'h80);
        send_req(OP_ALLOC, 2'd1, 8'h00);
        send_req(OP_ALLOC, 2'd2, 8'h00);
        send_req(OP_ALLOC, 2'd3, 8'h00);

        // Sizes one past the table, then out-of-range count and group number
        wait_idle();
        load_config(10, 4, 3, 0, 5, 3);
        send_req(OP_INIT, 2'd0, 8'h00);
        send_req(OP_ALLOC, 2'd0, 8'h00);
        wait_idle();
        load_config(0, 0, 0, 0, 0, 0);
        send_req(OP_INIT, 2'd0, 8'h00);
        wait_idle();
        load_config(TABLE_SLOTS + 1, 0, 0, 0, 0, 0);
        send_req(OP_INIT, 2'd0, 8'h00);
        wait_idle();
        load_config(TABLE_SLOTS, MAX_GROUPS + 1, 0, 0, 0, 0);
        send_req(OP_INIT, 2'd0, 8'h00);

        // Smallest table: one slot, then empty
        wait_idle();
        load_config(1, 0, 511, 511, 511, 511);
        send_req(OP_INIT, 2'd0, 8'h00);
        send_req(OP_ALLOC, 2'd0, 8'h00);
        send_req(OP_ALLOC, 2'd0, 8'h00);

        // Random settings, each followed by a burst of traffic
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            idle_pct = idle_choice[phase % 4];
            pick_config();
            if ($urandom_range(9) != 0) begin
                send_req(OP_INIT, 2'($urandom_range(3)), 8'($urandom_range(255)));
                random_sent++;
            end
            phase_len = $urandom_range(20, 120);
            for (int k = 0; k < phase_len; k++)
                random_req();
            random_sent += phase_len;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests, %0d of them queue rebuilds, over %0d register settings",
                 n_items, n_inits, n_settings);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
